>>> rtl/bounded_array_list_engine_macros.svh
// Assertion macros for the bounded array list engine.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define BALE_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("bounded_array_list_engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BALE_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("bounded_array_list_engine: next-cycle check failed");

`else

`define BALE_ASSERT_IMPL(name, clk, rst_n, pre, post)
`define BALE_ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

>>> rtl/bale_pkg.sv
// Types and constants shared by the bounded array list engine.
package bale_pkg;

    // Field widths of the request and result items
    localparam int ACTION_W   = 3;
    localparam int INDEX_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int RDATA_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int CAP_W      = 7;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - RDATA_W - STATUS_W - COUNT_W;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_READ   = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_SWAP   = 3'd4,
        ACT_REMOVE = 3'd5,
        ACT_CLEAR  = 3'd6
    } action_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_RD_WAIT  = 9'b000000100,
        S_SWAP_B   = 9'b000001000,
        S_SWAP_WA  = 9'b000010000,
        S_SWAP_WB  = 9'b000100000,
        S_SHIFT    = 9'b001000000,
        S_FINISH   = 9'b010000000,
        S_SPARE    = 9'b100000000
    } state_t;

endpackage

>>> rtl/bounded_array_list_engine.sv
// Bounded array list engine: list store with push, pop, indexed read and write, swap, remove and clear.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready | s_tuser: action; s_tdata: index_a,index_b,value
//  m_      | out       | m_tvalid / m_tready | m_tdata: data, status, count
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data: capacity
//
// A request runs from decode to finish, with a read wait for read and pop, a second read and two
// writes for swap and a shift for remove; the sequencer shares the memory's one read port and one
// write port between reads, writes and the one-element-a-cycle shift of remove.
// Reset (aresetn low, synchronous) empties the list and sets capacity to 64; no sweep runs.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register while the next request is taken and worked on.
module bounded_array_list_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bale_pkg::S_TDATA_W-1:0]   s_tdata,   // index_a[15:0], index_b[31:16], value[63:32]
    input  logic [bale_pkg::ACTION_W-1:0]    s_tuser,   // action[2:0]
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bale_pkg::M_TDATA_W-1:0]   m_tdata,   // data[31:0], status[33:32], count[40:34], zero pad
    // capacity write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bale_pkg::CAP_W-1:0]       cfg_data   // capacity[6:0]
);
    import bale_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer and list state
    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CAP_W-1:0]        capacity_reg;
    logic [AW-1:0]           ptr_reg, ptr_next;

    // Captured request
    action_t                 act_reg;
    logic [INDEX_W-1:0]      ia_reg;
    logic [INDEX_W-1:0]      ib_reg;
    logic [DATA_WIDTH-1:0]   val_reg;
    logic [DATA_WIDTH-1:0]   tmp_reg;

    // Result being built and result on the port
    logic [RDATA_W-1:0]      res_data_reg, res_data_next;
    status_t                 res_status_reg, res_status_next;
    logic                    m_tvalid_reg;
    logic [RDATA_W-1:0]      m_data_reg;
    status_t                 m_status_reg;
    logic [COUNT_W-1:0]      m_count_reg;

    // Element memory
    logic [DATA_WIDTH-1:0]   mem [DEPTH];
    logic [DATA_WIDTH-1:0]   mem_rdata_reg;
    logic [AW-1:0]           mem_raddr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [DATA_WIDTH-1:0]   mem_wdata;

    // Index and fill checks
    logic                    ok_a;
    logic                    ok_b;
    logic                    full;
    logic                    out_free;
    logic                    s_accept;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign ok_a = !ia_reg[INDEX_W-1] && (ia_reg < INDEX_W'(count_reg));
    assign ok_b = !ib_reg[INDEX_W-1] && (ib_reg < INDEX_W'(count_reg));
    assign full = (INDEX_W'(count_reg) >= INDEX_W'(capacity_reg)) ||
                  (INDEX_W'(count_reg) >= INDEX_W'(DEPTH));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_status_reg, m_data_reg};

    // Sequencer: checks, memory port use and result
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        mem_raddr       = ptr_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = mem_rdata_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_data_next   = '0;
                res_status_next = ST_OK;
                state_next      = S_FINISH;
                unique case (act_reg)
                    ACT_PUSH: begin
                        if (full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    ACT_POP: begin
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            count_next = count_reg - CW'(1);
                            mem_raddr  = AW'(count_reg - CW'(1));
                            state_next = S_RD_WAIT;
                        end
                    end
                    ACT_READ: begin
                        if (!ok_a) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            mem_raddr  = ia_reg[AW-1:0];
                            state_next = S_RD_WAIT;
                        end
                    end
                    ACT_WRITE: begin
                        if (!ok_a) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = ia_reg[AW-1:0];
                            mem_wdata = val_reg;
                        end
                    end
                    ACT_SWAP: begin
                        if (!ok_a || !ok_b) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            mem_raddr  = ia_reg[AW-1:0];
                            state_next = S_SWAP_B;
                        end
                    end
                    ACT_REMOVE: begin
                        if (!ok_a) begin
                            res_status_next = ST_RANGE;
                        end else if ((ia_reg + INDEX_W'(1)) < INDEX_W'(count_reg)) begin
                            // start the shift: fetch the element after the hole
                            ptr_next   = ia_reg[AW-1:0];
                            mem_raddr  = AW'(ia_reg + INDEX_W'(1));
                            state_next = S_SHIFT;
                        end else begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    ACT_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD_WAIT: begin
                res_data_next = RDATA_W'(mem_rdata_reg);
                state_next    = S_FINISH;
            end
            S_SWAP_B: begin
                // first element is in mem_rdata_reg and lands in tmp_reg
                mem_raddr  = ib_reg[AW-1:0];
                state_next = S_SWAP_WA;
            end
            S_SWAP_WA: begin
                mem_we     = 1'b1;
                mem_waddr  = ia_reg[AW-1:0];
                mem_wdata  = mem_rdata_reg;
                state_next = S_SWAP_WB;
            end
            S_SWAP_WB: begin
                mem_we     = 1'b1;
                mem_waddr  = ib_reg[AW-1:0];
                mem_wdata  = tmp_reg;
                state_next = S_FINISH;
            end
            S_SHIFT: begin
                // move element ptr+1 down to ptr, fetch ptr+2 at the same time
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata_reg;
                ptr_next  = ptr_reg + AW'(1);
                mem_raddr = AW'(INDEX_W'(ptr_reg) + INDEX_W'(2));
                if ((INDEX_W'(ptr_reg) + INDEX_W'(2)) >= INDEX_W'(count_reg)) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (state_reg == S_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        if (s_accept) begin
            act_reg <= action_t'(s_tuser);
            ia_reg  <= s_tdata[INDEX_W-1:0];
            ib_reg  <= s_tdata[2*INDEX_W-1:INDEX_W];
            val_reg <= DATA_WIDTH'(s_tdata[S_TDATA_W-1:2*INDEX_W]);
        end
        if (state_reg == S_SWAP_B) begin
            tmp_reg <= mem_rdata_reg;
        end
        if (state_reg == S_FINISH && out_free) begin
            m_data_reg   <= res_data_reg;
            m_status_reg <= res_status_reg;
            m_count_reg  <= COUNT_W'(count_reg);
        end
    end

    // Element memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

`include "bounded_array_list_engine_macros.svh"

    // count never runs past the store
    `BALE_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, INDEX_W'(count_reg) <= INDEX_W'(DEPTH))
    // an accepted request is decoded in the next cycle
    `BALE_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_accept, state_reg == S_DECODE)
    // a finished request shows up on the result port
    `BALE_ASSERT_NEXT(a_finish_out, aclk, aresetn, (state_reg == S_FINISH) && out_free, m_tvalid_reg && (state_reg == S_IDLE))
    // the memory is never written while idle
    `BALE_ASSERT_IMPL(a_idle_no_write, aclk, aresetn, state_reg == S_IDLE, !mem_we)

endmodule
